@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker module of the keypad code lock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define KCL_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("kcl: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent; reset is not masked.
`define KCL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("kcl: next-cycle check failed");

`endif

@@ hdl/kcl_pkg.sv @@
package kcl_pkg;

   localparam int KEY_COUNT_DEF   = 12;
   localparam int CODE_DIGITS_DEF = 4;

   localparam logic [31:0] KEY_STAR_CODE = 32'd512;
   localparam logic [31:0] KEY_HASH_CODE = 32'd2048;

   localparam logic [3:0]  FAIL_SAT            = 4'd15;
   localparam logic [3:0]  FAIL_LIMIT_RESET    = 4'd3;
   localparam logic [15:0] LOCKOUT_TICKS_RESET = 16'd10000;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_DIGIT,
      KIND_STAR,
      KIND_HASH
   } key_kind_type;

   typedef enum logic [2:0] {
      EV_NONE       = 3'd0,
      EV_DIGIT      = 3'd1,
      EV_SET_MODE   = 3'd2,
      EV_CODE_SET   = 3'd3,
      EV_DOOR_OPEN  = 3'd4,
      EV_WRONG_CODE = 3'd5,
      EV_IGNORED    = 3'd6
   } event_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FAIL_LIMIT    = 1'b0,
      CSR_LOCKOUT_TICKS = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [3:0]  fail_limit;
      logic [15:0] lockout_ticks;
   } cfg_type;

   function automatic logic [31:0] initial_code(input int slot);
      return (slot < 4) ? (32'd1 << slot) : 32'd0;
   endfunction

endpackage

@@ hdl/kcl_if.sv @@
interface kcl_req_if #(parameter int KEY_COUNT = kcl_pkg::KEY_COUNT_DEF);
   logic                 valid;
   logic                 ready;
   logic [KEY_COUNT-1:0] key_state;

   modport source (output valid, output key_state, input ready);
   modport sink   (input valid, input key_state, output ready);
endinterface

interface kcl_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] event_res;
   logic [3:0] fail_count;
   logic       locked;
   logic [2:0] entry_count;

   modport source (output valid, output event_res, output fail_count, output locked,
                   output entry_count, input ready);
   modport sink   (input valid, input event_res, input fail_count, input locked,
                   input entry_count, output ready);
endinterface

interface kcl_csr_if;
   logic                             valid;
   logic                             ready;
   logic [kcl_pkg::CSR_INDEX_W-1:0]  index;
   logic [kcl_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/kcl_queue.sv @@
module kcl_queue #(
   parameter int WIDTH = 14
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

@@ hdl/kcl_front.sv @@
module kcl_front #(
   parameter int KEY_COUNT = kcl_pkg::KEY_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   kcl_req_if.sink               req_if,
   output logic                  push_valid,
   input  logic                  push_ready,
   output kcl_pkg::key_kind_type push_kind,
   output logic [KEY_COUNT-1:0]  push_key
);
   import kcl_pkg::*;

   logic [KEY_COUNT-1:0] prev_keys_ff, prev_keys_in;
   logic                 accept;
   logic                 press;

   assign req_if.ready = push_ready;
   assign push_valid   = req_if.valid;
   assign push_key     = req_if.key_state;
   assign accept       = req_if.valid && push_ready;
   assign press        = (req_if.key_state != '0) && (prev_keys_ff == '0);

   always_comb begin
      prev_keys_in = accept ? req_if.key_state : prev_keys_ff;
      if (!press) begin
         push_kind = KIND_NONE;
      end else if (req_if.key_state == KEY_COUNT'(KEY_HASH_CODE)) begin
         push_kind = KIND_HASH;
      end else if (req_if.key_state == KEY_COUNT'(KEY_STAR_CODE)) begin
         push_kind = KIND_STAR;
      end else begin
         push_kind = KIND_DIGIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_keys_ff <= '0;
      end else begin
         prev_keys_ff <= prev_keys_in;
      end
   end
endmodule

@@ hdl/kcl_back.sv @@
module kcl_back #(
   parameter int CODE_DIGITS = kcl_pkg::CODE_DIGITS_DEF,
   parameter int KEY_COUNT   = kcl_pkg::KEY_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  kcl_pkg::cfg_type      cfg,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  kcl_pkg::key_kind_type pop_kind,
   input  logic [KEY_COUNT-1:0]  pop_key,
   kcl_rsp_if.source             rsp_if
);
   import kcl_pkg::*;

   localparam int IDX_W = $clog2(CODE_DIGITS + 1);

   logic                 set_mode_ff, set_mode_in;
   logic [IDX_W-1:0]     digit_index_ff, digit_index_in;
   logic [KEY_COUNT-1:0] stored_code_ff [CODE_DIGITS];
   logic [KEY_COUNT-1:0] stored_code_in [CODE_DIGITS];
   logic [KEY_COUNT-1:0] entry_ff [CODE_DIGITS];
   logic [KEY_COUNT-1:0] entry_in [CODE_DIGITS];
   logic [3:0]           failures_ff, failures_in;
   logic [15:0]          lockout_ff, lockout_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   event_type            event_ff, event_in;
   logic [3:0]           fail_count_ff, fail_count_in;
   logic                 locked_ff, locked_in;
   logic [2:0]           entry_count_ff, entry_count_in;

   logic                 take;
   logic                 codes_match;
   logic                 ignored;
   logic [3:0]           fail_next;
   logic [IDX_W+2:0]     index_wide;
   event_type            ev;

   assign pop_ready          = !rsp_valid_ff || rsp_if.ready;
   assign take               = pop_valid && pop_ready;
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.event_res   = event_ff;
   assign rsp_if.fail_count  = fail_count_ff;
   assign rsp_if.locked      = locked_ff;
   assign rsp_if.entry_count = entry_count_ff;

   always_comb begin
      codes_match = 1'b1;
      for (int i = 0; i < CODE_DIGITS; i++) begin
         if (stored_code_ff[i] != entry_ff[i]) begin
            codes_match = 1'b0;
         end
      end
   end

   assign fail_next = (failures_ff == FAIL_SAT) ? failures_ff : failures_ff + 4'd1;

   always_comb begin
      set_mode_in    = set_mode_ff;
      digit_index_in = digit_index_ff;
      stored_code_in = stored_code_ff;
      entry_in       = entry_ff;
      failures_in    = failures_ff;
      lockout_in     = lockout_ff;
      ignored        = 1'b0;
      ev             = EV_NONE;

      if (take) begin
         if (lockout_ff != '0) begin
            lockout_in = lockout_ff - 16'd1;
            ignored    = 1'b1;
            ev         = (pop_kind != KIND_NONE) ? EV_IGNORED : EV_NONE;
         end else if (pop_kind != KIND_NONE) begin
            if (set_mode_ff) begin
               if (pop_kind == KIND_HASH && digit_index_ff == IDX_W'(CODE_DIGITS)) begin
                  set_mode_in    = 1'b0;
                  digit_index_in = '0;
                  ev             = EV_CODE_SET;
               end else if (pop_kind == KIND_DIGIT &&
                            digit_index_ff < IDX_W'(CODE_DIGITS)) begin
                  for (int i = 0; i < CODE_DIGITS; i++) begin
                     if (digit_index_ff == IDX_W'(i)) begin
                        stored_code_in[i] = pop_key;
                     end
                  end
                  digit_index_in = digit_index_ff + IDX_W'(1);
                  ev             = EV_DIGIT;
               end else begin
                  ev = EV_IGNORED;
               end
            end else if (pop_kind == KIND_HASH) begin
               for (int i = 0; i < CODE_DIGITS; i++) begin
                  stored_code_in[i] = '0;
               end
               set_mode_in    = 1'b1;
               digit_index_in = '0;
               ev             = EV_SET_MODE;
            end else if (pop_kind == KIND_DIGIT && digit_index_ff < IDX_W'(CODE_DIGITS)) begin
               for (int i = 0; i < CODE_DIGITS; i++) begin
                  if (digit_index_ff == IDX_W'(i)) begin
                     entry_in[i] = pop_key;
                  end
               end
               digit_index_in = digit_index_ff + IDX_W'(1);
               ev             = EV_DIGIT;
            end else if (pop_kind == KIND_STAR && digit_index_ff == IDX_W'(CODE_DIGITS)) begin
               digit_index_in = '0;
               if (codes_match) begin
                  failures_in = '0;
                  ev          = EV_DOOR_OPEN;
               end else begin
                  failures_in = fail_next;
                  if (fail_next >= cfg.fail_limit) begin
                     lockout_in = cfg.lockout_ticks;
                  end
                  ev = EV_WRONG_CODE;
               end
            end else begin
               ev = EV_IGNORED;
            end
         end
      end
   end

   always_comb begin
      index_wide     = {3'b000, digit_index_in};
      rsp_valid_in   = rsp_valid_ff;
      event_in       = event_ff;
      fail_count_in  = fail_count_ff;
      locked_in      = locked_ff;
      entry_count_in = entry_count_ff;
      if (take) begin
         rsp_valid_in   = 1'b1;
         event_in       = ev;
         fail_count_in  = failures_in;
         locked_in      = ignored || (lockout_in != '0);
         entry_count_in = index_wide[2:0];
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_mode_ff    <= 1'b0;
         digit_index_ff <= '0;
         failures_ff    <= '0;
         lockout_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < CODE_DIGITS; i++) begin
            stored_code_ff[i] <= KEY_COUNT'(initial_code(i));
         end
      end else begin
         set_mode_ff    <= set_mode_in;
         digit_index_ff <= digit_index_in;
         failures_ff    <= failures_in;
         lockout_ff     <= lockout_in;
         rsp_valid_ff   <= rsp_valid_in;
         stored_code_ff <= stored_code_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff       <= entry_in;
      event_ff       <= event_in;
      fail_count_ff  <= fail_count_in;
      locked_ff      <= locked_in;
      entry_count_ff <= entry_count_in;
   end
endmodule

@@ hdl/keypad_code_lock_controller.sv @@
// Keypad code lock controller. Each request transaction carries one keypad sample and yields
// exactly one response transaction, in order. The block sustains one transaction per clock
// cycle while the response sink is ready: the front stage detects the press edge and classifies
// the key, a two-entry queue holds the classified samples, and the back stage applies the whole
// lock update, including the parallel compare of all code digits, combinationally into the
// response register. Each sample passes the queue slot and then the response register, and up
// to two further requests are taken while a response waits for the sink. Register writes are
// always accepted and must only be issued while the block is idle.
module keypad_code_lock_controller #(
   parameter int CODE_DIGITS = kcl_pkg::CODE_DIGITS_DEF,
   parameter int KEY_COUNT   = kcl_pkg::KEY_COUNT_DEF
) (
   input  logic      clock,
   input  logic      reset,
   kcl_req_if.sink   req_if,
   kcl_rsp_if.source rsp_if,
   kcl_csr_if.sink   csr_if
);
   import kcl_pkg::*;

   localparam int ITEM_W = $bits(key_kind_type) + KEY_COUNT;

   cfg_type              cfg_ff, cfg_in;
   logic                 push_valid, push_ready;
   key_kind_type         push_kind;
   logic [KEY_COUNT-1:0] push_key;
   logic                 pop_valid, pop_ready;
   logic [ITEM_W-1:0]    pop_data;

   assign csr_if.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         unique case (csr_index_type'(csr_if.index))
            CSR_FAIL_LIMIT:    cfg_in.fail_limit    = csr_if.data[3:0];
            CSR_LOCKOUT_TICKS: cfg_in.lockout_ticks = csr_if.data[15:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fail_limit    <= FAIL_LIMIT_RESET;
         cfg_ff.lockout_ticks <= LOCKOUT_TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   kcl_front #(
      .KEY_COUNT (KEY_COUNT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_kind  (push_kind),
      .push_key   (push_key)
   );

   kcl_queue #(
      .WIDTH (ITEM_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_kind, push_key}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   kcl_back #(
      .CODE_DIGITS (CODE_DIGITS),
      .KEY_COUNT   (KEY_COUNT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_kind  (key_kind_type'(pop_data[ITEM_W-1:KEY_COUNT])),
      .pop_key   (pop_data[KEY_COUNT-1:0]),
      .rsp_if    (rsp_if)
   );
endmodule

@@ hdl/kcl_checker.sv @@
`include "assert_macros.svh"

module kcl_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] event_res,
   input logic [3:0] fail_count,
   input logic       locked,
   input logic [2:0] entry_count
);
   import kcl_pkg::*;

   `KCL_ASSERT_NEXT(a_rsp_hold, !reset && rsp_valid && !rsp_ready, reset || (rsp_valid && $stable(event_res) && $stable(fail_count) && $stable(locked) && $stable(entry_count)))
   `KCL_ASSERT_NEXT(a_reset_idle, reset, !rsp_valid)
   `KCL_ASSERT_IMP(a_open_clears_fail, rsp_valid && event_res == EV_DOOR_OPEN, fail_count == 4'd0 && !locked)
   `KCL_ASSERT_IMP(a_mode_change_index, rsp_valid && (event_res == EV_SET_MODE || event_res == EV_CODE_SET || event_res == EV_DOOR_OPEN || event_res == EV_WRONG_CODE), entry_count == 3'd0)
endmodule

bind keypad_code_lock_controller kcl_checker u_kcl_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .event_res   (rsp_if.event_res),
   .fail_count  (rsp_if.fail_count),
   .locked      (rsp_if.locked),
   .entry_count (rsp_if.entry_count)
);
